// ===== rtl/imuoc_pkg.sv =====
// Shared types and constants for the IMU offset correction and calibration block.
// Holds the beat payloads, register indexes, orientation codes and reset offsets.
// No dependencies.
package imuoc_pkg;

	typedef logic signed [15:0] s16_t;
	typedef s16_t vec3_t [3];

	typedef struct packed {
		logic        op;
		logic        data_ready;
		logic        apply_accel_bias;
		logic signed [15:0] raw_ax;
		logic signed [15:0] raw_ay;
		logic signed [15:0] raw_az;
		logic signed [15:0] raw_gx;
		logic signed [15:0] raw_gy;
		logic signed [15:0] raw_gz;
	} sample_t;

	typedef struct packed {
		logic signed [15:0] out_ax;
		logic signed [15:0] out_ay;
		logic signed [15:0] out_az;
		logic signed [15:0] out_gx;
		logic signed [15:0] out_gy;
		logic signed [15:0] out_gz;
		logic [2:0]  orientation;
		logic signed [15:0] bias_x;
		logic signed [15:0] bias_y;
		logic signed [15:0] bias_z;
	} result_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [15:0] wdata;
	} cfg_t;

	typedef struct {
		vec3_t bias_now;
		vec3_t bias_nxt;
		logic [2:0] orientation;
	} cal_stat_t;

	localparam logic OP_CORRECT   = 1'b0;
	localparam logic OP_CALIBRATE = 1'b1;

	localparam logic [1:0] REG_GYRO_BIAS_X = 2'd0;
	localparam logic [1:0] REG_GYRO_BIAS_Y = 2'd1;
	localparam logic [1:0] REG_GYRO_BIAS_Z = 2'd2;

	localparam logic [2:0] ORIENT_NONE = 3'd6;

	localparam s16_t ACCEL_BIAS_X_RESET = -16'sd8;
	localparam s16_t ACCEL_BIAS_Y_RESET = 16'sd25;
	localparam s16_t ACCEL_BIAS_Z_RESET = 16'sd141;
	localparam s16_t GYRO_BIAS_X_RESET  = -16'sd14;
	localparam s16_t GYRO_BIAS_Y_RESET  = 16'sd15;
	localparam s16_t GYRO_BIAS_Z_RESET  = -16'sd7;

endpackage

// ===== rtl/imuoc_chan_if.sv =====
// Valid/ready channel carrying one payload beat per handshake.
// The payload type is given by the instantiating module; no package dependency.
interface imuoc_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/imuoc_calib.sv =====
// Accelerometer calibration state: peak records, offsets and dominant axis search.
// Depends on imuoc_pkg.
module imuoc_calib (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              calibrate,
	input  logic              fire,
	input  imuoc_pkg::vec3_t  accel,
	output imuoc_pkg::cal_stat_t stat
);
	import imuoc_pkg::*;

	vec3_t      bias_q;
	vec3_t      high_q;
	vec3_t      low_q;
	vec3_t      bias_nxt;
	s16_t       hi_new;
	s16_t       lo_new;
	s16_t       sel;
	s16_t       other;
	logic [16:0] mag [3];
	logic [16:0] ext;
	logic [16:0] sum;
	logic [16:0] adj;
	logic [1:0]  axis;
	logic        neg;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ext = {accel[i][15], accel[i]};
			mag[i] = accel[i][15] ? (~ext + 17'd1) : ext;
		end
		// Ties resolve toward x, then y.
		if (mag[0] >= mag[1] && mag[0] >= mag[2]) begin
			axis = 2'd0;
		end else if (mag[1] >= mag[2]) begin
			axis = 2'd1;
		end else begin
			axis = 2'd2;
		end
		sel = accel[axis];
		neg = sel[15];
		hi_new = neg ? high_q[axis] : sel;
		lo_new = neg ? sel : low_q[axis];
		other = neg ? high_q[axis] : low_q[axis];
		sum = {hi_new[15], hi_new} + {lo_new[15], lo_new};
		// Adding the sign bit before the shift truncates toward zero.
		adj = sum + {16'd0, sum[16]};
		bias_nxt = bias_q;
		if (calibrate && other != 16'sd0) begin
			bias_nxt[axis] = adj[16:1];
		end
		stat.bias_now = bias_q;
		stat.bias_nxt = bias_nxt;
		stat.orientation = calibrate ? {axis, ~neg} : ORIENT_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q[0] <= ACCEL_BIAS_X_RESET;
			bias_q[1] <= ACCEL_BIAS_Y_RESET;
			bias_q[2] <= ACCEL_BIAS_Z_RESET;
			for (int i = 0; i < 3; i++) begin
				high_q[i] <= '0;
				low_q[i] <= '0;
			end
		end else if (calibrate && fire) begin
			bias_q <= bias_nxt;
			high_q[axis] <= hi_new;
			low_q[axis] <= lo_new;
		end
	end

endmodule

// ===== rtl/imu_offset_correct_and_calibrate_unit.sv =====
// Top level of the IMU offset correction and calibration block.
// Depends on imuoc_pkg, imuoc_chan_if and imuoc_calib.
//
//   channel  role  beat payload
//   sample   sink  op, data_ready, apply_accel_bias, raw_ax .. raw_gz
//   result   src   out_ax .. out_gz, orientation, bias_x .. bias_z
//   cfg      sink  index, wdata (gyro offset registers 0 to 2)
//
// A sample beat lands in the input register and its result then in the result
// register; a beat is taken every cycle unless the result stalls. Calibration
// state and the held sample update as an item leaves the input register. A
// stalled result holds both registers; reset sets all state but their data.
module imu_offset_correct_and_calibrate_unit (
	input logic          clk,
	input logic          arst_n,
	imuoc_chan_if.sink   sample,
	imuoc_chan_if.source result,
	imuoc_chan_if.sink   cfg
);
	import imuoc_pkg::*;

	sample_t   s1_q;
	logic      s1_valid_q;
	result_t   res_q;
	logic      res_valid_q;
	vec3_t     last_acc_q;
	vec3_t     last_gyr_q;
	s16_t      gbias_x_q;
	s16_t      gbias_y_q;
	s16_t      gbias_z_q;
	vec3_t     cur_acc;
	vec3_t     cur_gyr;
	result_t   res_nxt;
	cal_stat_t stat;
	logic      advance;
	logic      fire;
	logic      calibrate;
	logic      correct_acc;

	assign advance = !res_valid_q || result.ready;
	assign fire = s1_valid_q && advance;
	assign sample.ready = !s1_valid_q || advance;
	assign cfg.ready = 1'b1;
	assign calibrate = s1_valid_q && (s1_q.op == OP_CALIBRATE);
	assign correct_acc = (s1_q.op == OP_CORRECT) && s1_q.apply_accel_bias;

	always_comb begin
		if (s1_q.data_ready) begin
			cur_acc[0] = s1_q.raw_ax;
			cur_acc[1] = s1_q.raw_ay;
			cur_acc[2] = s1_q.raw_az;
			cur_gyr[0] = s1_q.raw_gx;
			cur_gyr[1] = s1_q.raw_gy;
			cur_gyr[2] = s1_q.raw_gz;
		end else begin
			cur_acc = last_acc_q;
			cur_gyr = last_gyr_q;
		end
	end

	imuoc_calib u_calib (
		.clk       (clk),
		.arst_n    (arst_n),
		.calibrate (calibrate),
		.fire      (fire),
		.accel     (cur_acc),
		.stat      (stat)
	);

	always_comb begin
		res_nxt.out_ax = correct_acc ? cur_acc[0] - stat.bias_now[0] : cur_acc[0];
		res_nxt.out_ay = correct_acc ? cur_acc[1] - stat.bias_now[1] : cur_acc[1];
		res_nxt.out_az = correct_acc ? cur_acc[2] - stat.bias_now[2] : cur_acc[2];
		res_nxt.out_gx = cur_gyr[0] - gbias_x_q;
		res_nxt.out_gy = cur_gyr[1] - gbias_y_q;
		res_nxt.out_gz = cur_gyr[2] - gbias_z_q;
		res_nxt.orientation = stat.orientation;
		res_nxt.bias_x = stat.bias_nxt[0];
		res_nxt.bias_y = stat.bias_nxt[1];
		res_nxt.bias_z = stat.bias_nxt[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (sample.valid && sample.ready) begin
				s1_valid_q <= 1'b1;
			end else if (fire) begin
				s1_valid_q <= 1'b0;
			end
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			s1_q <= sample.data;
		end
		if (fire) begin
			res_q <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				last_acc_q[i] <= '0;
				last_gyr_q[i] <= '0;
			end
		end else if (fire) begin
			last_acc_q <= cur_acc;
			last_gyr_q <= cur_gyr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gbias_x_q <= GYRO_BIAS_X_RESET;
			gbias_y_q <= GYRO_BIAS_Y_RESET;
			gbias_z_q <= GYRO_BIAS_Z_RESET;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.data.index)
				REG_GYRO_BIAS_X: gbias_x_q <= cfg.data.wdata;
				REG_GYRO_BIAS_Y: gbias_y_q <= cfg.data.wdata;
				REG_GYRO_BIAS_Z: gbias_z_q <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

	assign result.valid = res_valid_q;
	assign result.data = res_q;

endmodule

// ===== test/imuoc_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the IMU offset correction and calibration block: watches the
// sample, result and register channels, predicts each result and compares it.
// Depends on imuoc_pkg.
module imuoc_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	input  logic               sample_ready,
	input  imuoc_pkg::sample_t sample_data,
	input  logic               result_valid,
	input  logic               result_ready,
	input  imuoc_pkg::result_t result_data,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  imuoc_pkg::cfg_t    cfg_data,
	output int                 fails,
	output int                 outstanding
);
	import imuoc_pkg::*;

	s16_t    gyro_offset [3];
	s16_t    held_sample [6];
	s16_t    accel_offset [3];
	s16_t    peak_high [3];
	s16_t    peak_low [3];
	result_t corrected_q [$];
	result_t want;
	int      fail_count = 0;

	function automatic result_t predict_correction(input sample_t s);
		result_t r;
		int      mag [3];
		int      axis;
		int      other;
		int      sum;
		logic    pos;
		if (s.data_ready) begin
			held_sample[0] = s.raw_ax;
			held_sample[1] = s.raw_ay;
			held_sample[2] = s.raw_az;
			held_sample[3] = s.raw_gx;
			held_sample[4] = s.raw_gy;
			held_sample[5] = s.raw_gz;
		end
		r.orientation = ORIENT_NONE;
		if (s.op == OP_CALIBRATE) begin
			for (int i = 0; i < 3; i++)
				mag[i] = held_sample[i] < 0 ? -int'(held_sample[i]) : int'(held_sample[i]);
			if (mag[0] >= mag[1] && mag[0] >= mag[2])
				axis = 0;
			else if (mag[1] >= mag[2])
				axis = 1;
			else
				axis = 2;
			pos = held_sample[axis] >= 0;
			r.orientation = 3'(axis * 2 + int'(pos));
			if (pos) begin
				peak_high[axis] = held_sample[axis];
				other = peak_low[axis];
			end else begin
				peak_low[axis] = held_sample[axis];
				other = peak_high[axis];
			end
			if (other != 0) begin
				sum = int'(peak_high[axis]) + int'(peak_low[axis]);
				accel_offset[axis] = s16_t'(sum / 2);
			end
		end
		if (s.op == OP_CORRECT && s.apply_accel_bias) begin
			r.out_ax = held_sample[0] - accel_offset[0];
			r.out_ay = held_sample[1] - accel_offset[1];
			r.out_az = held_sample[2] - accel_offset[2];
		end else begin
			r.out_ax = held_sample[0];
			r.out_ay = held_sample[1];
			r.out_az = held_sample[2];
		end
		r.out_gx = held_sample[3] - gyro_offset[0];
		r.out_gy = held_sample[4] - gyro_offset[1];
		r.out_gz = held_sample[5] - gyro_offset[2];
		r.bias_x = accel_offset[0];
		r.bias_y = accel_offset[1];
		r.bias_z = accel_offset[2];
		return r;
	endfunction

	task automatic check_field(input string name, input logic [15:0] exp_v,
			input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, $signed(exp_v),
				$signed(act_v));
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_offset = '{GYRO_BIAS_X_RESET, GYRO_BIAS_Y_RESET, GYRO_BIAS_Z_RESET};
			accel_offset = '{ACCEL_BIAS_X_RESET, ACCEL_BIAS_Y_RESET, ACCEL_BIAS_Z_RESET};
			held_sample = '{default: '0};
			peak_high = '{default: '0};
			peak_low = '{default: '0};
			corrected_q.delete();
			outstanding <= 0;
			fails <= fail_count;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_data.index)
					REG_GYRO_BIAS_X: gyro_offset[0] = cfg_data.wdata;
					REG_GYRO_BIAS_Y: gyro_offset[1] = cfg_data.wdata;
					REG_GYRO_BIAS_Z: gyro_offset[2] = cfg_data.wdata;
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (corrected_q.size() == 0) begin
					$display("%0t: result beat with nothing expected, got %h", $time,
						result_data);
					fail_count++;
				end else begin
					want = corrected_q.pop_front();
					check_field("out_ax", want.out_ax, result_data.out_ax);
					check_field("out_ay", want.out_ay, result_data.out_ay);
					check_field("out_az", want.out_az, result_data.out_az);
					check_field("out_gx", want.out_gx, result_data.out_gx);
					check_field("out_gy", want.out_gy, result_data.out_gy);
					check_field("out_gz", want.out_gz, result_data.out_gz);
					check_field("orientation", {13'd0, want.orientation},
						{13'd0, result_data.orientation});
					check_field("bias_x", want.bias_x, result_data.bias_x);
					check_field("bias_y", want.bias_y, result_data.bias_y);
					check_field("bias_z", want.bias_z, result_data.bias_z);
				end
			end
			if (sample_valid && sample_ready)
				corrected_q.push_back(predict_correction(sample_data));
			outstanding <= corrected_q.size();
			fails <= fail_count;
		end
	end

endmodule

// ===== test/imu_offset_correct_and_calibrate_unit_tb.sv =====
`timescale 1ns / 100ps
// Top of the testbench for imu_offset_correct_and_calibrate_unit: drives directed
// and random sample beats, gyro offset writes and result back-pressure.
// Depends on imuoc_pkg, imuoc_chan_if, the block itself and imuoc_checker.
module imu_offset_correct_and_calibrate_unit_tb;
	import imuoc_pkg::*;

	localparam int ITEMS_PER_PHASE = 345;
	localparam int HOLD_AT = 200;
	localparam int HOLD_CYCLES = 80;

	logic clk;
	logic arst_n;
	bit   bursts_on = 1'b1;
	int   sent = 0;
	int   fails;
	int   outstanding;

	imuoc_chan_if #(.payload_t(sample_t)) sample_ch ();
	imuoc_chan_if #(.payload_t(result_t)) result_ch ();
	imuoc_chan_if #(.payload_t(cfg_t))    cfg_ch ();

	imu_offset_correct_and_calibrate_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	imuoc_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_ch.valid),
		.sample_ready (sample_ch.ready),
		.sample_data  (sample_ch.data),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_data  (result_ch.data),
		.cfg_valid    (cfg_ch.valid),
		.cfg_ready    (cfg_ch.ready),
		.cfg_data     (cfg_ch.data),
		.fails        (fails),
		.outstanding  (outstanding)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic sample_t make_sample(input logic op, input logic fresh,
			input logic apply, input int ax, input int ay, input int az,
			input int gx, input int gy, input int gz);
		sample_t s;
		s.op = op;
		s.data_ready = fresh;
		s.apply_accel_bias = apply;
		s.raw_ax = ax[15:0];
		s.raw_ay = ay[15:0];
		s.raw_az = az[15:0];
		s.raw_gx = gx[15:0];
		s.raw_gy = gy[15:0];
		s.raw_gz = gz[15:0];
		return s;
	endfunction

	function automatic int extreme_value();
		int v;
		case ($urandom_range(0, 5))
			0: v = -32768;
			1: v = 32767;
			2: v = 0;
			3: v = -1;
			4: v = 1;
			default: v = -32767;
		endcase
		return v;
	endfunction

	// Half the beats look like a board resting in one of the six poses, so that
	// calibration keeps finding real peaks on both sides of each axis.
	function automatic sample_t random_sample();
		int   a [6];
		int   kind;
		int   axis;
		int   g;
		logic op;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 6; i++) begin
			if (kind < 5)
				a[i] = int'($urandom_range(0, 1600)) - 800;
			else if (kind < 7)
				a[i] = int'($urandom_range(0, 65535)) - 32768;
			else if (kind == 7)
				a[i] = extreme_value();
			else
				a[i] = int'($urandom_range(0, 400)) - 200;
		end
		if (kind < 5) begin
			axis = $urandom_range(0, 2);
			g = 16384 + int'($urandom_range(0, 1200)) - 600;
			a[axis] = $urandom_range(0, 1) ? -g : g;
		end
		op = ($urandom_range(0, 9) < 3) ? OP_CALIBRATE : OP_CORRECT;
		return make_sample(op, $urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)),
			a[0], a[1], a[2], a[3], a[4], a[5]);
	endfunction

	task automatic send_sample(input sample_t s);
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data <= s;
		do @(posedge clk); while (!sample_ch.ready);
		sent++;
	endtask

	task automatic settle();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_gyro_offsets(input s16_t x, input s16_t y, input s16_t z);
		cfg_t w [3];
		w[0] = '{index: REG_GYRO_BIAS_X, wdata: x};
		w[1] = '{index: REG_GYRO_BIAS_Y, wdata: y};
		w[2] = '{index: REG_GYRO_BIAS_Z, wdata: z};
		for (int i = 0; i < 3; i++) begin
			cfg_ch.valid <= 1'b1;
			cfg_ch.data <= w[i];
			do @(posedge clk); while (!cfg_ch.ready);
		end
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin : result_sink
		bit held_off;
		held_off = 1'b0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!held_off && sent >= HOLD_AT) begin
				held_off = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (bursts_on && $urandom_range(0, 3) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		sample_t directed [$];
		arst_n <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed.push_back(make_sample(OP_CORRECT, 1'b0, 1'b1, 1234, 1234, 1234, 1234,
			1234, 1234));
		directed.push_back(make_sample(OP_CORRECT, 1'b1, 1'b0, 32767, -32768, 0, 32767,
			-32768, -1));
		directed.push_back(make_sample(OP_CORRECT, 1'b1, 1'b1, -32768, 32767, -1,
			-32768, 32767, 0));
		directed.push_back(make_sample(OP_CORRECT, 1'b0, 1'b1, 5, 5, 5, 5, 5, 5));
		directed.push_back(make_sample(OP_CALIBRATE, 1'b1, 1'b0, 16384, 100, -200, 3, 4, 5));
		directed.push_back(make_sample(OP_CALIBRATE, 1'b1, 1'b1, -16000, 50, 60, 7, 8, 9));
		directed.push_back(make_sample(OP_CALIBRATE, 1'b1, 1'b0, 10, 15999, -20, 0, 0, 0));
		directed.push_back(make_sample(OP_CALIBRATE, 1'b1, 1'b0, 30, -16002, 40, 0, 0, 0));
		directed.push_back(make_sample(OP_CALIBRATE, 1'b1, 1'b0, 1000, 1000, 1000, 1, 1, 1));
		directed.push_back(make_sample(OP_CALIBRATE, 1'b1, 1'b0, -1000, 1000, -1000, 2, 2,
			2));
		directed.push_back(make_sample(OP_CALIBRATE, 1'b1, 1'b0, 10, -500, 500, 3, 3, 3));
		directed.push_back(make_sample(OP_CALIBRATE, 1'b1, 1'b0, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_sample(OP_CALIBRATE, 1'b1, 1'b0, -300, 0, 0, 0, 0, 0));
		directed.push_back(make_sample(OP_CALIBRATE, 1'b1, 1'b0, 0, 0, 20000, 0, 0, 0));
		directed.push_back(make_sample(OP_CALIBRATE, 1'b1, 1'b0, 0, 0, -32768, 0, 0, 0));
		directed.push_back(make_sample(OP_CALIBRATE, 1'b1, 1'b0, 32767, -32768, 0, 0, 0, 0));
		directed.push_back(make_sample(OP_CALIBRATE, 1'b1, 1'b0, 0, 0, 32767, 0, 0, 0));
		directed.push_back(make_sample(OP_CALIBRATE, 1'b0, 1'b1, -5, -5, -5, -5, -5, -5));
		directed.push_back(make_sample(OP_CORRECT, 1'b1, 1'b1, 1, 2, 3, 4, 5, 6));
		directed.push_back(make_sample(OP_CORRECT, 1'b1, 1'b1, -32768, -32768, -32768,
			-32768, -32768, -32768));
		directed.push_back(make_sample(OP_CORRECT, 1'b1, 1'b0, 32767, 32767, 32767, 32767,
			32767, 32767));
		directed.push_back(make_sample(OP_CALIBRATE, 1'b1, 1'b0, 0, -1, 0, 0, 0, 0));
		foreach (directed[i])
			send_sample(directed[i]);
		settle();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				1: write_gyro_offsets(16'sd32767, -16'sd32768, 16'sd0);
				2: write_gyro_offsets(-16'sd32768, 16'sd32767, -16'sd1);
				3: write_gyro_offsets(s16_t'($urandom), s16_t'($urandom), s16_t'($urandom));
				default: ;
			endcase
			if (phase == 3)
				bursts_on = 1'b0;
			repeat (ITEMS_PER_PHASE)
				send_sample(random_sample());
			settle();
		end

		if (fails == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin : watchdog
		#400000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== imu_offset_correct_and_calibrate_unit.f =====
rtl/imuoc_pkg.sv
rtl/imuoc_chan_if.sv
rtl/imuoc_calib.sv
rtl/imu_offset_correct_and_calibrate_unit.sv
test/imuoc_checker.sv
test/imu_offset_correct_and_calibrate_unit_tb.sv
